// File: hdl/smac_pkg.sv
// Package for the softmax/argmax class mask unit.
// Holds the sizes, the register map, the payload and control structs, and the exp helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smac_pkg;

    localparam int MAX_CLASSES = 6;
    localparam int NUM_COLORS  = 6;

    localparam int LOGIT_W    = 16;
    localparam int THR_W      = 17;
    localparam int COLOR_W    = 24;
    localparam int CLASS_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int CNT_W  = $clog2(MAX_CLASSES + 1);
    localparam int IDX_W  = $clog2(MAX_CLASSES);
    localparam int TERM_W = 9;
    localparam int SUM_W  = $clog2(MAX_CLASSES * 256 + 1);
    localparam int T_W    = 17;
    localparam int PROD_W = THR_W + SUM_W;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_LAST =
        CFG_COLOR0 + CFG_IDX_W'(NUM_COLORS - 1);

    localparam logic [THR_W-1:0] THR_RESET = 17'h10000;

    // round(256 * 2^(-k/16))
    localparam logic [TERM_W-1:0] POW2 [16] = '{
        9'd256, 9'd245, 9'd235, 9'd225, 9'd215, 9'd206, 9'd197, 9'd189,
        9'd181, 9'd173, 9'd166, 9'd159, 9'd152, 9'd146, 9'd140, 9'd134
    };

    typedef struct packed {
        logic signed [LOGIT_W-1:0] logit;
        logic                      last_class;
        logic                      first_of_frame;
    } in_item_t;

    typedef struct packed {
        logic [CLASS_W-1:0] class_index;
        logic [COLOR_W-1:0] color;
        logic               foreground_seen;
    } out_item_t;

    typedef struct packed {
        logic load;     // input transaction taken
        logic step;     // walk one stored logit
        logic mult;     // threshold times sum
        logic finish;   // decide and load the output register
    } dp_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic out_free;
    } dp_status_t;

    // d in Q8.8 scaled by log2(e), result in Q8.8 powers of two
    function automatic logic [T_W-1:0] scale_log2e(input logic [LOGIT_W-1:0] d);
        logic [LOGIT_W+8:0] p;
        p = {9'd0, d} * 25'd369;
        return p[LOGIT_W+8:8];
    endfunction

    function automatic logic [TERM_W-1:0] exp_term(input logic [T_W-1:0] t);
        logic [8:0]        n;
        logic [TERM_W-1:0] base;
        n    = t[16:8];
        base = POW2[t[7:4]];
        if (n >= 9'd9)
            return '0;
        return base >> n[3:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/smac_ctrl.sv
// Controller for the softmax/argmax class mask unit.
// Sequences input acceptance, the exp walk, the threshold multiply and the decision.
// Depends on smac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smac_ctrl
    import smac_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_last,
    output logic            in_stall,
    output dp_cmd_t         cmd,
    input  wire dp_status_t status
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WALK   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                        state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.step = 1'b1;
                if (status.walk_done)
                    state_next = S_DRAIN;
            end
            // last term lands in the accumulator
            S_DRAIN:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mult   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// File: hdl/smac_datapath.sv
// Datapath for the softmax/argmax class mask unit.
// Logit store, running max, exp accumulator, threshold multiply, config and output registers.
// Depends on smac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smac_datapath
    import smac_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire in_item_t              in_data,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic        [THR_W-1:0]   thr_reg;
    logic        [COLOR_W-1:0] color_reg [NUM_COLORS];
    logic signed [LOGIT_W-1:0] store_reg [MAX_CLASSES];

    logic signed [LOGIT_W-1:0] max_reg,     max_next;
    logic        [IDX_W-1:0]   max_cls_reg, max_cls_next;
    logic        [CNT_W-1:0]   count_reg,   count_next;
    logic                      flag_reg,    flag_next;
    logic        [IDX_W-1:0]   idx_reg,     idx_next;
    logic        [T_W-1:0]     t_reg,       t_next;
    logic                      tv_reg,      tv_next;
    logic        [SUM_W-1:0]   acc_reg,     acc_next;
    logic        [PROD_W-1:0]  prod_reg,    prod_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_data_reg,  out_data_next;

    logic                      store_we;
    logic        [LOGIT_W-1:0] diff;
    logic        [CLASS_W-1:0] cls;
    logic        [IDX_W-1:0]   color_sel;

    assign status.walk_done = (CNT_W'(idx_reg) + CNT_W'(1) == count_reg);
    assign status.out_free  = !out_valid_reg || !out_stall;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;

    assign store_we = cmd.load && (count_reg < CNT_W'(MAX_CLASSES));
    assign diff     = LOGIT_W'(max_reg - store_reg[idx_reg]);

    always_comb
    begin
        // T * S < 2^24 means 1/S > T
        cls = (prod_reg[PROD_W-1:24] == '0) ? CLASS_W'(max_cls_reg) : '0;
        if (cls >= CLASS_W'(NUM_COLORS))
            cls = '0;
        color_sel = IDX_W'(cls);
    end

    always_comb
    begin
        max_next       = max_reg;
        max_cls_next   = max_cls_reg;
        count_next     = count_reg;
        flag_next      = flag_reg;
        idx_next       = idx_reg;
        t_next         = t_reg;
        tv_next        = cmd.step;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        if (tv_reg)
            acc_next = acc_reg + SUM_W'(exp_term(t_reg));

        if (cmd.load)
        begin
            if (in_data.first_of_frame)
                flag_next = 1'b0;
            if (store_we)
            begin
                if (count_reg == '0 || in_data.logit > max_reg)
                begin
                    max_next     = in_data.logit;
                    max_cls_next = count_reg[IDX_W-1:0];
                end
                count_next = count_reg + CNT_W'(1);
            end
            if (in_data.last_class)
            begin
                idx_next = '0;
                acc_next = '0;
            end
        end

        if (cmd.step)
        begin
            t_next   = scale_log2e(diff);
            idx_next = idx_reg + IDX_W'(1);
        end

        if (cmd.mult)
            prod_next = PROD_W'(thr_reg) * PROD_W'(acc_reg);

        if (cmd.finish)
        begin
            flag_next                     = flag_reg || (cls != '0);
            out_data_next.class_index     = cls;
            out_data_next.color           = color_reg[color_sel];
            out_data_next.foreground_seen = flag_reg || (cls != '0);
            out_valid_next                = 1'b1;
            count_next                    = '0;
            max_next                      = '0;
            max_cls_next                  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= '0;
            max_cls_reg   <= '0;
            count_reg     <= '0;
            flag_reg      <= 1'b0;
            idx_reg       <= '0;
            tv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            thr_reg       <= THR_RESET;
            for (int i = 0; i < NUM_COLORS; i++)
                color_reg[i] <= '0;
        end
        else
        begin
            max_reg       <= max_next;
            max_cls_reg   <= max_cls_next;
            count_reg     <= count_next;
            flag_reg      <= flag_next;
            idx_reg       <= idx_next;
            tv_reg        <= tv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_THRESHOLD)
                    thr_reg <= cfg_data[THR_W-1:0];
                else if (cfg_index inside {[CFG_COLOR0:CFG_COLOR_LAST]})
                    color_reg[IDX_W'(cfg_index - CFG_COLOR0)] <= cfg_data[COLOR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
        if (store_we)
            store_reg[count_reg[IDX_W-1:0]] <= in_data.logit;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CLASSES))
        else $error("logit count past MAX_CLASSES");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while held");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (count_reg == '0 && out_valid_reg))
        else $error("pixel not closed after decision");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (CNT_W'(idx_reg) < count_reg))
        else $error("exp walk past stored logits");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.class_index == '0 || out_data_reg.foreground_seen))
        else $error("foreground class without foreground flag");

endmodule

`default_nettype wire

// File: hdl/softmax_argmax_class_mask_unit.sv
// Top level of the softmax/argmax class mask unit.
// Joins smac_ctrl and smac_datapath; depends on smac_pkg.
//
// Takes one signed Q8.8 logit per transaction; last_class closes the pixel and produces one
// result (class index, its color register, sticky foreground flag). A logit that does not
// close a pixel is taken without stalling the input. A closing logit holds the input while the
// shared exp unit walks the N logits kept for the pixel (at most MAX_CLASSES), one stored
// logit per cycle, then while the accumulator drains, the product with the threshold is
// formed and the decision is made. The decision waits while a previous result is still stalled.
// Logits past MAX_CLASSES in a pixel are dropped; ties go to the first maximum. Configuration
// writes are taken in any cycle and should only be issued while the unit is idle.
`timescale 1ns / 1ps
`default_nettype none

module softmax_argmax_class_mask_unit
    import smac_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    smac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_data.last_class),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    smac_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

// File: sim/softmax_argmax_class_mask_unit_test.sv
// Self-checking test for softmax_argmax_class_mask_unit: directed pixels, then random pixels.
// Expected labels come from a behavioral class predictor kept inside this file.
// Depends on smac_pkg and the unit's RTL.
`timescale 1ns / 1ps

module softmax_argmax_class_mask_unit_test;
    import smac_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_LOGITS  = 250;

    // one past the color registers, must be ignored by the unit
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_COLOR_LAST + 1'b1;

    typedef enum logic [1:0] {SET_RESET, SET_OPEN, SET_STRICT} dir_setting_e;

    typedef struct packed {
        logic [LOGIT_W-1:0] logit;
        logic               last;
        logic               fof;
        dir_setting_e       setting;
        logic               typed;
        out_item_t          want;
    } dir_row_t;

    localparam out_item_t BLANK_LABEL = '0;

    localparam dir_row_t PLAN [23] = '{
        // reset threshold is 1.0: nothing passes, colors are zero
        '{16'h7FFF, 1'b1, 1'b1, SET_RESET,  1'b1, '{3'd0, 24'd0, 1'b0}},
        '{16'h8000, 1'b0, 1'b0, SET_RESET,  1'b0, BLANK_LABEL},
        '{16'h7FFF, 1'b1, 1'b0, SET_RESET,  1'b1, '{3'd0, 24'd0, 1'b0}},
        // threshold 0: winner always passes; seventh logit is dropped
        '{16'h0100, 1'b0, 1'b1, SET_OPEN,   1'b0, BLANK_LABEL},
        '{16'h0200, 1'b0, 1'b0, SET_OPEN,   1'b0, BLANK_LABEL},
        '{16'h0300, 1'b0, 1'b0, SET_OPEN,   1'b0, BLANK_LABEL},
        '{16'h0100, 1'b0, 1'b0, SET_OPEN,   1'b0, BLANK_LABEL},
        '{16'h0080, 1'b0, 1'b0, SET_OPEN,   1'b0, BLANK_LABEL},
        '{16'h0400, 1'b0, 1'b0, SET_OPEN,   1'b0, BLANK_LABEL},
        '{16'h7FFF, 1'b1, 1'b0, SET_OPEN,   1'b0, BLANK_LABEL},
        // tie goes to the first maximum
        '{16'h0500, 1'b0, 1'b0, SET_OPEN,   1'b0, BLANK_LABEL},
        '{16'h0500, 1'b1, 1'b0, SET_OPEN,   1'b0, BLANK_LABEL},
        '{16'h0000, 1'b1, 1'b1, SET_OPEN,   1'b0, BLANK_LABEL},
        '{16'hFF00, 1'b0, 1'b0, SET_OPEN,   1'b0, BLANK_LABEL},
        '{16'hFF80, 1'b1, 1'b0, SET_OPEN,   1'b0, BLANK_LABEL},
        '{16'h8000, 1'b1, 1'b1, SET_OPEN,   1'b0, BLANK_LABEL},
        // threshold just under 1.0: only a lone or far-ahead winner passes
        '{16'h8000, 1'b0, 1'b0, SET_STRICT, 1'b0, BLANK_LABEL},
        '{16'h7FFF, 1'b1, 1'b0, SET_STRICT, 1'b0, BLANK_LABEL},
        '{16'h0100, 1'b0, 1'b0, SET_STRICT, 1'b0, BLANK_LABEL},
        '{16'h0180, 1'b1, 1'b0, SET_STRICT, 1'b0, BLANK_LABEL},
        // frame start flagged on a middle logit
        '{16'h0000, 1'b0, 1'b0, SET_STRICT, 1'b0, BLANK_LABEL},
        '{16'h0010, 1'b0, 1'b1, SET_STRICT, 1'b0, BLANK_LABEL},
        '{16'h1000, 1'b1, 1'b0, SET_STRICT, 1'b0, BLANK_LABEL}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    logic signed [LOGIT_W-1:0] px_logit [MAX_CLASSES];
    logic signed [LOGIT_W-1:0] peak = '0;
    int                        peak_cls = 0;
    int                        px_count = 0;
    bit                        fg_flag = 1'b0;
    logic [THR_W-1:0]          thr = THR_RESET;
    logic [COLOR_W-1:0]        palette [NUM_COLORS] = '{default: '0};

    out_item_t label_q [$];
    int        errors = 0;
    int        cycles = 0;
    int        logits_sent = 0;
    int        pixels_sent = 0;
    int        labels_seen = 0;
    int        gap_max = 13;
    int        stall_max = 13;
    int        stall_left = 0;

    softmax_argmax_class_mask_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d labels pending", cycles, label_q.size());
            $display("softmax_argmax_class_mask_unit_test NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // fixed-point exp(-d) for d in Q8.8, weight in Q8.8
    function automatic int unsigned softmax_weight(input int unsigned d);
        int unsigned t;
        int unsigned shift;
        t     = (d * 369) >> 8;
        shift = t >> 8;
        if (shift >= 9)
            return 0;
        return int'(POW2[(t >> 4) & 15]) >> shift;
    endfunction

    function automatic void classify_logit(input in_item_t it, output bit closes,
                                           output out_item_t lab);
        int unsigned wsum;
        int          win;
        closes = it.last_class;
        lab    = '0;
        if (it.first_of_frame)
            fg_flag = 1'b0;
        if (px_count < MAX_CLASSES)
        begin
            px_logit[px_count] = it.logit;
            if (px_count == 0 || it.logit > peak)
            begin
                peak     = it.logit;
                peak_cls = px_count;
            end
            px_count++;
        end
        if (!closes)
            return;
        wsum = 0;
        for (int i = 0; i < px_count; i++)
            wsum += softmax_weight(int'(peak) - int'(px_logit[i]));
        // 1/S > T/2^16 done exactly as T*S < 2^24
        win = 0;
        if (longint'(thr) * longint'(wsum) < (longint'(1) << 24))
            win = peak_cls;
        if (win != 0)
            fg_flag = 1'b1;
        lab.class_index     = CLASS_W'(win);
        lab.color           = palette[win];
        lab.foreground_seen = fg_flag;
        px_count = 0;
        peak     = '0;
        peak_cls = 0;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_THRESHOLD)
            thr = val[THR_W-1:0];
        else if (idx >= CFG_COLOR0 && idx <= CFG_COLOR_LAST)
            palette[idx - CFG_COLOR0] = val;
    endtask

    task automatic apply_setting(input dir_setting_e s);
        logic [COLOR_W-1:0] hues [NUM_COLORS];
        hues = '{24'hFFFFFF, 24'h123456, 24'hABCDEF, 24'h00FF00, 24'h800000, 24'h000001};
        case (s)
            SET_OPEN:
            begin
                write_reg(CFG_THRESHOLD, 24'd0);
                for (int k = 0; k < NUM_COLORS; k++)
                    write_reg(CFG_COLOR0 + CFG_IDX_W'(k), hues[k]);
                write_reg(CFG_SPARE, 24'hDEAD00);
            end
            SET_STRICT:
                write_reg(CFG_THRESHOLD, 24'd65535);
            default:
                ;
        endcase
        cfg_we <= 1'b0;
    endtask

    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        int        gap;
        bit        closes;
        out_item_t lab;
        gap = $urandom_range(0, gap_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        classify_logit(it, closes, lab);
        logits_sent++;
        if (closes)
        begin
            label_q.push_back(typed ? want : lab);
            pixels_sent++;
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (label_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_random_pixel();
        int       len;
        int       mode;
        int       base;
        int       spread;
        int       v;
        in_item_t it;
        len    = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 9) : $urandom_range(1, 6);
        mode   = $urandom_range(0, 9);
        base   = int'($urandom_range(0, 65535)) - 32768;
        spread = ($urandom_range(0, 3) == 0) ? 'h1000 : 'h300;
        for (int k = 0; k < len; k++)
        begin
            if (mode <= 5)
                v = base + int'($urandom_range(0, 2 * spread)) - spread;
            else if (mode <= 7)
                v = int'($urandom_range(0, 65535)) - 32768;
            else
                v = ($urandom_range(0, 1) == 0) ? base : base - 'h40;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            it.logit          = LOGIT_W'(v);
            it.last_class     = (k == len - 1);
            it.first_of_frame = (k == 0) ? ($urandom_range(0, 5) == 0)
                                         : ($urandom_range(0, 19) == 0);
            send_item(it, 1'b0, BLANK_LABEL);
        end
    endtask

    // result side: random stall after each transaction, checks against the oldest label
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            labels_seen++;
            if (label_q.size() == 0)
                report_mismatch("result with no pixel pending", out_data, 0);
            else
            begin
                want = label_q.pop_front();
                if (out_data.class_index !== want.class_index)
                    report_mismatch("class_index", out_data.class_index, want.class_index);
                if (out_data.color !== want.color)
                    report_mismatch("color", out_data.color, want.color);
                if (out_data.foreground_seen !== want.foreground_seen)
                    report_mismatch("foreground_seen", out_data.foreground_seen,
                                    want.foreground_seen);
            end
            stall_left = $urandom_range(0, stall_max);
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        dir_setting_e   cur;
        int             phase_logits;
        logic [THR_W-1:0] ladder [RANDOM_PHASES];
        logic [COLOR_W-1:0] hue;
        ladder = '{17'd65536, 17'd0, 17'd65535, 17'd40000, 17'd0, 17'd24000, 17'd1};
        ladder[4] = THR_W'($urandom_range(0, 65536));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur = SET_RESET;
        foreach (PLAN[r])
        begin
            if (PLAN[r].setting != cur)
            begin
                wait_drain();
                cur = PLAN[r].setting;
                apply_setting(cur);
            end
            send_item('{PLAN[r].logit, PLAN[r].last, PLAN[r].fof}, PLAN[r].typed,
                      PLAN[r].want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drain();
            write_reg(CFG_THRESHOLD, CFG_DATA_W'(ladder[p]));
            for (int k = 0; k < NUM_COLORS; k++)
            begin
                if (p == 1)
                    hue = 24'hFFFFFF;
                else if (p == 2)
                    hue = 24'h000000;
                else
                    hue = COLOR_W'($urandom_range(0, 24'hFFFFFF));
                write_reg(CFG_COLOR0 + CFG_IDX_W'(k), hue);
            end
            cfg_we <= 1'b0;
            // some phases run one side or the other without idle cycles
            gap_max   = (p % 3 == 1) ? 0 : 13;
            stall_max = (p % 3 == 2) ? 0 : 13;
            phase_logits = logits_sent;
            while (logits_sent - phase_logits < PHASE_LOGITS)
                send_random_pixel();
        end

        wait_drain();
        $display("sent %0d logits in %0d pixels, checked %0d labels", logits_sent,
                 pixels_sent, labels_seen);
        $display("covered %0d random register settings after the directed pixels",
                 RANDOM_PHASES);
        if (errors == 0)
            $display("softmax_argmax_class_mask_unit_test OK");
        else
            $display("softmax_argmax_class_mask_unit_test NOT OK");
        $finish;
    end

endmodule

// File: sim.f
hdl/smac_pkg.sv
hdl/smac_ctrl.sv
hdl/smac_datapath.sv
hdl/softmax_argmax_class_mask_unit.sv
sim/softmax_argmax_class_mask_unit_test.sv
